// ===== src/pbfb_pkg.sv =====
// ----------------------------------------------------------------------------
// pbfb_pkg
// Shared types and constants for the packet bit-field buffer.
// ----------------------------------------------------------------------------
`default_nettype none
package pbfb_pkg;
  localparam int FIELD_W  = 32;
  localparam int COUNT_W  = 6;
  localparam int OFFSET_W = 5;
  localparam int HDR_W    = 7;
  localparam logic [HDR_W-1:0] HEADER_MAX = 7'd64;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EXCEEDS  = 2'd1,
    ST_PAST_END = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    KIND_WRITE = 1'b0,
    KIND_READ  = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    BS_IDLE  = 2'd0,
    BS_CLEAR = 2'd1,
    BS_READ  = 2'd2,
    BS_WAIT  = 2'd3
  } back_state_t;

  // Classified item handed from the front to the back
  typedef struct packed {
    logic               kind;
    logic [FIELD_W-1:0] word;
    logic [COUNT_W-1:0] count;
    logic [OFFSET_W-1:0] offset;
    logic               bad_field;
  } cmd_t;
endpackage
`default_nettype wire

// ===== src/pbfb_if.sv =====
// ----------------------------------------------------------------------------
// pbfb_in_if / pbfb_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none
interface pbfb_in_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [pbfb_pkg::FIELD_W-1:0]  field_value;
  logic [pbfb_pkg::COUNT_W-1:0]  bit_count;
  logic [pbfb_pkg::OFFSET_W-1:0] field_offset;
  modport source (output valid, kind, field_value, bit_count, field_offset, input ready);
  modport sink   (input valid, kind, field_value, bit_count, field_offset, output ready);
endinterface

interface pbfb_out_if;
  logic                         valid;
  logic                         ready;
  logic [pbfb_pkg::FIELD_W-1:0] result_word;
  logic [1:0]                   status;
  modport source (output valid, result_word, status, input ready);
  modport sink   (input valid, result_word, status, output ready);
endinterface
`default_nettype wire

// ===== src/pbfb_front.sv =====
// ----------------------------------------------------------------------------
// pbfb_front
// Accepts items, checks the field bounds and queues them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module pbfb_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  pbfb_in_if.sink            in_ch,
  output pbfb_pkg::cmd_t     cmd,
  output logic               cmd_valid,
  input  wire logic          cmd_pop
);
  // Two-entry queue
  pbfb_pkg::cmd_t q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, rd_nxt;
  logic       push;
  pbfb_pkg::cmd_t in_cmd;
  logic [6:0] span;

  assign span = {2'b0, in_ch.field_offset} + {1'b0, in_ch.bit_count};
  always_comb begin
    in_cmd.kind      = in_ch.kind;
    in_cmd.word      = in_ch.field_value;
    in_cmd.count     = in_ch.bit_count;
    in_cmd.offset    = in_ch.field_offset;
    in_cmd.bad_field = (span > 7'(pbfb_pkg::FIELD_W));
  end

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign cmd_valid   = (cnt_r != 2'd0);
  assign cmd         = q_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r + 2'(push) - 2'(cmd_pop);
    rd_nxt  = rd_r ^ cmd_pop;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      rd_r  <= rd_nxt;
    end
    if (push) q_r[rd_r ^ (cnt_r[0] | cnt_r[1])] <= in_cmd;
  end
endmodule
`default_nettype wire

// ===== src/pbfb_back.sv =====
// ----------------------------------------------------------------------------
// pbfb_back
// Executes field writes and reads on the byte store, one 32-bit lane a step.
// ----------------------------------------------------------------------------
`default_nettype none
module pbfb_back #(
  parameter int STORE_BYTES = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_we,
  input  wire logic [pbfb_pkg::HDR_W-1:0] cfg_wdata,
  input  wire pbfb_pkg::cmd_t           cmd,
  input  wire logic                     cmd_valid,
  output logic                          cmd_pop,
  pbfb_out_if.source                    out_ch
);
  localparam int AW = $clog2(STORE_BYTES);
  localparam int PW = AW + 4;          // bit position up to STORE_BYTES*8
  localparam int WA = AW - 2;          // store is organized as 32-bit words
  localparam int WORDS = STORE_BYTES / 4;

  // Word-wide store: a 32-bit field spans at most two words
  logic [31:0] mem [WORDS];

  pbfb_pkg::back_state_t st_r, st_nxt;
  logic [PW-1:0] wpos_r, rpos_r;
  logic [AW:0]   wend_r;
  logic [WA:0]   clr_r;
  logic [1:0]    phase_r;
  logic [31:0]   rd_data_r, lo_r;
  logic [WA-1:0] addr;
  logic          mem_we;
  logic [31:0]   mem_wd;
  logic          ovalid_r;
  logic [31:0]   oword_r;
  logic [1:0]    ostat_r;
  logic [pbfb_pkg::HDR_W-1:0] hdr;

  logic [PW-1:0] pos, endpos;
  logic [4:0]    sh;
  logic [63:0]   fmask, fdata, pair, newpair;
  logic [31:0]   fld, cmask, outword;
  logic [1:0]    chk;

  assign hdr = (cfg_wdata > pbfb_pkg::HEADER_MAX) ? pbfb_pkg::HEADER_MAX : cfg_wdata;
  assign pos    = (cmd.kind == pbfb_pkg::KIND_READ) ? rpos_r : wpos_r;
  assign endpos = pos + PW'(cmd.count);
  assign sh     = pos[4:0];
  assign cmask  = (cmd.count >= 6'd32) ? 32'hFFFF_FFFF : ((32'd1 << cmd.count) - 32'd1);
  assign fld    = (cmd.word >> cmd.offset) & cmask;
  assign fmask  = {32'd0, cmask} << sh;
  assign fdata  = {32'd0, fld} << sh;

  always_comb begin
    if (cmd.bad_field) chk = pbfb_pkg::ST_EXCEEDS;
    else if (cmd.kind == pbfb_pkg::KIND_WRITE) begin
      chk = ({1'b0, endpos} > (PW+1)'(STORE_BYTES * 8)) ? pbfb_pkg::ST_FULL : pbfb_pkg::ST_OK;
    end else begin
      chk = ({1'b0, endpos} > {1'b0, wend_r, 3'b0}) ? pbfb_pkg::ST_PAST_END : pbfb_pkg::ST_OK;
    end
  end

  // Phase 0: read low word, 1: read high word, 2: combine, write low, 3: write high
  assign pair    = {rd_data_r, lo_r};
  assign newpair = (pair & ~fmask) | (fdata & fmask);
  always_comb begin
    outword = cmd.word;
    if (cmd.kind == pbfb_pkg::KIND_READ && chk == pbfb_pkg::ST_OK)
      outword = (cmd.word & ~(cmask << cmd.offset)) |
                ((32'((pair >> sh)) & cmask) << cmd.offset);
  end

  always_comb begin
    addr   = pos[PW-2:5];
    mem_we = 1'b0;
    mem_wd = newpair[31:0];
    if (st_r == pbfb_pkg::BS_CLEAR) begin
      addr = clr_r[WA-1:0]; mem_we = 1'b1; mem_wd = '0;
    end else if (st_r == pbfb_pkg::BS_READ) begin
      if (phase_r == 2'd1 || phase_r == 2'd3) addr = pos[PW-2:5] + WA'(1);
      if (phase_r == 2'd2) mem_we = (cmd.kind == pbfb_pkg::KIND_WRITE);
      if (phase_r == 2'd3) begin
        mem_wd = newpair[63:32];
        mem_we = (cmd.kind == pbfb_pkg::KIND_WRITE) && (pos[PW-2:5] != {(WA){1'b1}});
      end
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      pbfb_pkg::BS_CLEAR: if (clr_r == (WA+1)'(WORDS - 1)) st_nxt = pbfb_pkg::BS_IDLE;
      pbfb_pkg::BS_IDLE:  if (cmd_valid && !ovalid_r) begin
        st_nxt = (chk == pbfb_pkg::ST_OK) ? pbfb_pkg::BS_READ : pbfb_pkg::BS_WAIT;
      end
      pbfb_pkg::BS_READ:  if (phase_r == 2'd3) st_nxt = pbfb_pkg::BS_WAIT;
      pbfb_pkg::BS_WAIT:  st_nxt = pbfb_pkg::BS_IDLE;
      default:            st_nxt = pbfb_pkg::BS_IDLE;
    endcase
  end

  assign cmd_pop = (st_r == pbfb_pkg::BS_WAIT);
  assign out_ch.valid       = ovalid_r;
  assign out_ch.result_word = oword_r;
  assign out_ch.status      = ostat_r;

  always_ff @(posedge clk) begin
    if (mem_we) mem[addr] <= mem_wd;
    // hold the high word through the write phases and the result step
    if (!(st_r == pbfb_pkg::BS_READ && phase_r[1])) rd_data_r <= mem[addr];
    if (st_r == pbfb_pkg::BS_READ && phase_r == 2'd1) lo_r <= rd_data_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= pbfb_pkg::BS_CLEAR;
      clr_r    <= '0;
      phase_r  <= '0;
      ovalid_r <= 1'b0;
      wpos_r   <= '0;
      rpos_r   <= '0;
      wend_r   <= '0;
    end else begin
      st_r <= st_nxt;
      if (st_r == pbfb_pkg::BS_CLEAR) clr_r <= clr_r + 1'b1;
      if (st_r == pbfb_pkg::BS_READ) phase_r <= phase_r + 2'd1;
      else phase_r <= '0;
      if (out_ch.ready) ovalid_r <= 1'b0;
      if (st_r == pbfb_pkg::BS_WAIT) begin
        ovalid_r <= 1'b1;
        oword_r  <= outword;
        ostat_r  <= chk;
        // advance cursors on success
        if (chk == pbfb_pkg::ST_OK && cmd.kind == pbfb_pkg::KIND_WRITE) begin
          wpos_r <= endpos;
          if ((endpos + PW'(7)) >> 3 > PW'(wend_r)) wend_r <= (AW+1)'((endpos + PW'(7)) >> 3);
        end
        if (chk == pbfb_pkg::ST_OK && cmd.kind == pbfb_pkg::KIND_READ) rpos_r <= endpos;
      end
      if (cfg_we) begin
        wpos_r <= PW'({hdr, 3'b0});
        rpos_r <= PW'({hdr, 3'b0});
        wend_r <= (AW+1)'(hdr);
      end
    end
  end
endmodule
`default_nettype wire

// ===== src/packet_bit_field_buffer_core.sv =====
// Steps: an item that fails its checks goes through pick-up and result only; a
// field access goes through pick-up, two word reads, two word writes, result.
// One item is worked at a time, bounded by the single store port and the single
// result register: no new item is picked up while a result waits to be taken.
// Reset: synchronous, active low; the store is then cleared one 32-bit word a
// cycle, all STORE_BYTES/4 words, before the first item is executed.
// ----------------------------------------------------------------------------
// packet_bit_field_buffer_core
// Bit packer/unpacker over a packet byte store, LSB first within each byte.
// ----------------------------------------------------------------------------
`default_nettype none
module packet_bit_field_buffer_core #(
  parameter int STORE_BYTES = 2048
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [pbfb_pkg::HDR_W-1:0] cfg_wdata,
  pbfb_in_if.sink                         in_ch,
  pbfb_out_if.source                      out_ch
);
  pbfb_pkg::cmd_t cmd;
  logic cmd_valid, cmd_pop;

  pbfb_front u_front (.clk, .rst_n, .in_ch, .cmd, .cmd_valid, .cmd_pop);
  pbfb_back #(.STORE_BYTES(STORE_BYTES)) u_back (
    .clk, .rst_n, .cfg_we, .cfg_wdata, .cmd, .cmd_valid, .cmd_pop, .out_ch);

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> cmd_valid) else $error("pop from empty queue");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid) else $error("result dropped");
  a_pop_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |=> !cmd_pop) else $error("double pop");
endmodule
`default_nettype wire
